>>> sv/rccs_pkg.sv
// Shared types and constants of the range coverage cluster selector.
`default_nettype none
package rccs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BND_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CP_W        = 21;
    localparam int IDX_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int FACE_W      = 3;
    localparam int SRC_W       = 2;
    localparam int ENTRY_W     = FACE_W + 2 * CP_W;

    // op codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // coverage set bits
    localparam logic [FACE_W-1:0] FACE_EMOJI = 3'h1;
    localparam logic [FACE_W-1:0] FACE_MONO  = 3'h2;
    localparam logic [FACE_W-1:0] FACE_TEXT  = 3'h4;
    localparam logic [FACE_W-1:0] FACE_ALL   = 3'h7;

    // source choice codes
    localparam logic [SRC_W-1:0] SRC_NONE  = 2'd0;
    localparam logic [SRC_W-1:0] SRC_MONO  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_EMOJI = 2'd2;
    localparam logic [SRC_W-1:0] SRC_TEXT  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_HIT,
        ST_FINISH
    } rccs_state_t;

    typedef struct packed {
        logic write;       // store the accepted entry
        logic start;       // latch lookup request, open search bounds
        logic rd_en;       // table read
        logic rd_low;      // read at low bound rather than midpoint
        logic step;        // narrow bounds from read data
        logic merge_hit;   // AND candidate entry's set into mask
        logic merge_miss;  // no entry holds the point: mask clears
        logic emit;        // load result register, mask back to all ones
    } rccs_cmd_t;

    typedef struct packed {
        logic search_open;   // low < high
        logic low_in_range;  // low < entry count
        logic last_item;     // request closes a cluster
        logic out_blocked;   // result register full and stalled
    } rccs_sts_t;

endpackage
`default_nettype wire

>>> sv/rccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem_reg[raddr];
        end
    end

    assign rdata = q_reg;

endmodule
`default_nettype wire

>>> sv/rccs_ctrl.sv
// Sequencer: request acceptance, binary search steps, result hand-off.
`default_nettype none
module rccs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              op,
    input  rccs_pkg::rccs_sts_t    sts,
    output rccs_pkg::rccs_cmd_t    cmd,
    output logic                   in_stall
);

    rccs_pkg::rccs_state_t state_reg;
    rccs_pkg::rccs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rccs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rccs_pkg::ST_IDLE:
            begin
                if (in_valid && op == rccs_pkg::OP_LOOKUP)
                begin
                    state_next = rccs_pkg::ST_SEARCH;
                end
            end
            rccs_pkg::ST_SEARCH:
            begin
                if (sts.search_open)
                begin
                    state_next = rccs_pkg::ST_CMP;
                end
                else if (sts.low_in_range)
                begin
                    state_next = rccs_pkg::ST_HIT;
                end
                else
                begin
                    state_next = rccs_pkg::ST_FINISH;
                end
            end
            rccs_pkg::ST_CMP:
            begin
                state_next = rccs_pkg::ST_SEARCH;
            end
            rccs_pkg::ST_HIT:
            begin
                state_next = rccs_pkg::ST_FINISH;
            end
            rccs_pkg::ST_FINISH:
            begin
                if (!sts.last_item || !sts.out_blocked)
                begin
                    state_next = rccs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rccs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            rccs_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.write = (op == rccs_pkg::OP_WRITE);
                    cmd.start = (op == rccs_pkg::OP_LOOKUP);
                end
            end
            rccs_pkg::ST_SEARCH:
            begin
                if (sts.search_open)
                begin
                    cmd.rd_en = 1'b1;
                end
                else if (sts.low_in_range)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_low = 1'b1;
                end
                else
                begin
                    cmd.merge_miss = 1'b1;
                end
            end
            rccs_pkg::ST_CMP:
            begin
                cmd.step = 1'b1;
            end
            rccs_pkg::ST_HIT:
            begin
                cmd.merge_hit = 1'b1;
            end
            rccs_pkg::ST_FINISH:
            begin
                cmd.emit = sts.last_item && !sts.out_blocked;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/rccs_dp.sv
// Datapath: range table, search bounds, cluster mask and result register.
`default_nettype none
module rccs_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  rccs_pkg::rccs_cmd_t                    cmd,
    output rccs_pkg::rccs_sts_t                    sts,
    input  wire logic                              cfg_write_en,
    input  wire logic [rccs_pkg::COUNT_W-1:0]      cfg_write_data,
    input  wire logic [rccs_pkg::IDX_W-1:0]        entry_index,
    input  wire logic [rccs_pkg::CP_W-1:0]         range_first,
    input  wire logic [rccs_pkg::CP_W-1:0]         range_last,
    input  wire logic [rccs_pkg::FACE_W-1:0]       face_bits,
    input  wire logic [rccs_pkg::CP_W-1:0]         code_point,
    input  wire logic                              last_in_cluster,
    input  wire logic                              text_plane,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [rccs_pkg::SRC_W-1:0]        source_choice,
    output logic      [rccs_pkg::FACE_W-1:0]       cluster_mask
);

    logic [rccs_pkg::COUNT_W-1:0] count_reg;
    logic [rccs_pkg::BND_W-1:0]   bound_reg;
    logic [rccs_pkg::BND_W-1:0]   bound_next;
    logic [rccs_pkg::BND_W-1:0]   low_reg;
    logic [rccs_pkg::BND_W-1:0]   low_next;
    logic [rccs_pkg::BND_W-1:0]   high_reg;
    logic [rccs_pkg::BND_W-1:0]   high_next;
    logic [rccs_pkg::BND_W-1:0]   mid;
    logic [rccs_pkg::CP_W-1:0]    cp_reg;
    logic                         last_reg;
    logic                         plane_reg;
    logic [rccs_pkg::FACE_W-1:0]  mask_reg;
    logic [rccs_pkg::FACE_W-1:0]  mask_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [rccs_pkg::SRC_W-1:0]   src_reg;
    logic [rccs_pkg::FACE_W-1:0]  omask_reg;
    logic [rccs_pkg::SRC_W-1:0]   src_sel;

    logic                         wr_ok;
    logic [rccs_pkg::ADDR_W-1:0]  raddr;
    logic [rccs_pkg::ENTRY_W-1:0] wdata;
    logic [rccs_pkg::ENTRY_W-1:0] rdata;
    logic [rccs_pkg::CP_W-1:0]    q_first;
    logic [rccs_pkg::CP_W-1:0]    q_last;
    logic [rccs_pkg::FACE_W-1:0]  q_faces;

    // entry layout: {faces, last, first}
    assign wdata   = {face_bits, range_last, range_first};
    assign q_first = rdata[rccs_pkg::CP_W-1:0];
    assign q_last  = rdata[2*rccs_pkg::CP_W-1:rccs_pkg::CP_W];
    assign q_faces = rdata[rccs_pkg::ENTRY_W-1:2*rccs_pkg::CP_W];

    // out-of-depth writes are dropped
    assign wr_ok = cmd.write && (int'(entry_index) < rccs_pkg::TABLE_DEPTH);
    assign mid   = low_reg + ((high_reg - low_reg) >> 1);
    assign raddr = cmd.rd_low ? low_reg[rccs_pkg::ADDR_W-1:0]
                              : mid[rccs_pkg::ADDR_W-1:0];

    rccs_ram #(
        .WIDTH (rccs_pkg::ENTRY_W),
        .DEPTH (rccs_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (rccs_pkg::ADDR_W'(entry_index)),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // saturate count to table depth
    always_comb
    begin
        if (int'(count_reg) > rccs_pkg::TABLE_DEPTH)
        begin
            bound_next = rccs_pkg::BND_W'(rccs_pkg::TABLE_DEPTH);
        end
        else
        begin
            bound_next = rccs_pkg::BND_W'(count_reg);
        end
    end

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (cmd.start)
        begin
            low_next  = '0;
            high_next = bound_next;
        end
        else if (cmd.step)
        begin
            if (q_last < cp_reg)
            begin
                low_next = mid + rccs_pkg::BND_W'(1);
            end
            else
            begin
                high_next = mid;
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.merge_miss)
        begin
            mask_next = '0;
        end
        else if (cmd.merge_hit)
        begin
            mask_next = (q_first > cp_reg) ? '0 : (mask_reg & q_faces);
        end
        else if (cmd.emit)
        begin
            mask_next = rccs_pkg::FACE_ALL;
        end
    end

    // priority pick: text plane prefers mono, else colour emoji first
    always_comb
    begin
        if (mask_reg == '0)
        begin
            src_sel = rccs_pkg::SRC_NONE;
        end
        else if (plane_reg)
        begin
            if ((mask_reg & rccs_pkg::FACE_MONO) != '0)
            begin
                src_sel = rccs_pkg::SRC_MONO;
            end
            else if ((mask_reg & rccs_pkg::FACE_TEXT) != '0)
            begin
                src_sel = rccs_pkg::SRC_TEXT;
            end
            else
            begin
                src_sel = rccs_pkg::SRC_EMOJI;
            end
        end
        else
        begin
            if ((mask_reg & rccs_pkg::FACE_EMOJI) != '0)
            begin
                src_sel = rccs_pkg::SRC_EMOJI;
            end
            else if ((mask_reg & rccs_pkg::FACE_MONO) != '0)
            begin
                src_sel = rccs_pkg::SRC_MONO;
            end
            else
            begin
                src_sel = rccs_pkg::SRC_TEXT;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            bound_reg     <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            mask_reg      <= rccs_pkg::FACE_ALL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                count_reg <= cfg_write_data;
            end
            if (cmd.start)
            begin
                bound_reg <= bound_next;
            end
            low_reg       <= low_next;
            high_reg      <= high_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cp_reg    <= code_point;
            last_reg  <= last_in_cluster;
            plane_reg <= text_plane;
        end
        if (cmd.emit)
        begin
            src_reg   <= src_sel;
            omask_reg <= mask_reg;
        end
    end

    assign sts.search_open  = low_reg < high_reg;
    assign sts.low_in_range = low_reg < bound_reg;
    assign sts.last_item    = last_reg;
    assign sts.out_blocked  = out_valid_reg && out_stall;

    assign out_valid     = out_valid_reg;
    assign source_choice = src_reg;
    assign cluster_mask  = omask_reg;

endmodule
`default_nettype wire

>>> sv/range_coverage_cluster_selector_top.sv
// Top level of the range coverage cluster selector.
`default_nettype none
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// request   | in_valid / in_stall  | op, entry_index, range_first, range_last,
//           |                      | face_bits, code_point, last_in_cluster,
//           |                      | text_plane
// result    | out_valid / out_stall| source_choice, cluster_mask
// config    | cfg_write_en         | cfg_write_data (entry count)
//
// A write request is taken while idle and goes straight into the table.
// A lookup request is a binary search on the single table read port: each
// step is a table read, then a compare that narrows the search bounds.
// Reset: asynchronous, active low; clears the count and the cluster mask
// (to all ones); table contents are undefined until written.
// One result can wait in the output register while the next request is
// taken; a closing lookup holds until that register is free.
module range_coverage_cluster_selector_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_write_en,
    input  wire logic [rccs_pkg::COUNT_W-1:0] cfg_write_data,
    // request channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         op,
    input  wire logic [rccs_pkg::IDX_W-1:0]   entry_index,
    input  wire logic [rccs_pkg::CP_W-1:0]    range_first,
    input  wire logic [rccs_pkg::CP_W-1:0]    range_last,
    input  wire logic [rccs_pkg::FACE_W-1:0]  face_bits,
    input  wire logic [rccs_pkg::CP_W-1:0]    code_point,
    input  wire logic                         last_in_cluster,
    input  wire logic                         text_plane,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [rccs_pkg::SRC_W-1:0]   source_choice,
    output logic      [rccs_pkg::FACE_W-1:0]  cluster_mask
);

    rccs_pkg::rccs_cmd_t cmd;
    rccs_pkg::rccs_sts_t sts;

    // sequencer: owns the request handshake
    rccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // table, search bounds, mask and result register
    rccs_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .entry_index     (entry_index),
        .range_first     (range_first),
        .range_last      (range_last),
        .face_bits       (face_bits),
        .code_point      (code_point),
        .last_in_cluster (last_in_cluster),
        .text_plane      (text_plane),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .source_choice   (source_choice),
        .cluster_mask    (cluster_mask)
    );

    // an empty mask, and only an empty mask, names no source
    a_none_iff_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((source_choice == rccs_pkg::SRC_NONE) == (cluster_mask == '0)))
        else $error("source choice disagrees with empty mask");

    // a mono choice must be covered by the mask
    a_choice_covered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && source_choice == rccs_pkg::SRC_MONO |-> cluster_mask[1])
        else $error("mono chosen but not covered");

    // a lookup request always occupies the sequencer for the next cycle
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == rccs_pkg::OP_LOOKUP |=> in_stall)
        else $error("lookup did not start a search");

    // a table write completes in its own cycle
    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == rccs_pkg::OP_WRITE |=> !in_stall)
        else $error("table write held the request channel");

endmodule
`default_nettype wire

>>> bench/cluster_result_checker.sv
// Checker for the range coverage cluster selector: tracks the table, predicts results, compares.
module cluster_result_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [rccs_pkg::COUNT_W-1:0] cfg_write_data,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire logic                         op,
    input  wire logic [rccs_pkg::IDX_W-1:0]   entry_index,
    input  wire logic [rccs_pkg::CP_W-1:0]    range_first,
    input  wire logic [rccs_pkg::CP_W-1:0]    range_last,
    input  wire logic [rccs_pkg::FACE_W-1:0]  face_bits,
    input  wire logic [rccs_pkg::CP_W-1:0]    code_point,
    input  wire logic                         last_in_cluster,
    input  wire logic                         text_plane,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [rccs_pkg::SRC_W-1:0]   source_choice,
    input  wire logic [rccs_pkg::FACE_W-1:0]  cluster_mask,
    output int                                mismatch_count,
    output int                                pending_results,
    output int                                results_checked
);

    typedef struct packed {
        logic [rccs_pkg::SRC_W-1:0]  choice;
        logic [rccs_pkg::FACE_W-1:0] mask;
    } cluster_result_t;

    logic [rccs_pkg::CP_W-1:0]    span_first [rccs_pkg::TABLE_DEPTH];
    logic [rccs_pkg::CP_W-1:0]    span_last  [rccs_pkg::TABLE_DEPTH];
    logic [rccs_pkg::FACE_W-1:0]  span_faces [rccs_pkg::TABLE_DEPTH];
    logic [rccs_pkg::COUNT_W-1:0] entry_limit;
    logic [rccs_pkg::FACE_W-1:0]  cluster_acc;
    cluster_result_t              expected_results [$];

    // same search as the block: first entry whose end is not below the point
    function automatic logic [rccs_pkg::FACE_W-1:0] covering_set(
        input logic [rccs_pkg::CP_W-1:0] cp);
        int n;
        int lo;
        int hi;
        int mid;
        n  = (entry_limit > rccs_pkg::TABLE_DEPTH) ? rccs_pkg::TABLE_DEPTH
                                                   : int'(entry_limit);
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (span_last[mid] < cp)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo >= n || span_first[lo] > cp)
            return '0;
        return span_faces[lo];
    endfunction

    function automatic logic [rccs_pkg::SRC_W-1:0] pick_source(
        input logic [rccs_pkg::FACE_W-1:0] mask,
        input logic plane);
        if (mask == '0)
            return rccs_pkg::SRC_NONE;
        if (plane)
        begin
            if ((mask & rccs_pkg::FACE_MONO) != '0)
                return rccs_pkg::SRC_MONO;
            if ((mask & rccs_pkg::FACE_TEXT) != '0)
                return rccs_pkg::SRC_TEXT;
            return rccs_pkg::SRC_EMOJI;
        end
        if ((mask & rccs_pkg::FACE_EMOJI) != '0)
            return rccs_pkg::SRC_EMOJI;
        if ((mask & rccs_pkg::FACE_MONO) != '0)
            return rccs_pkg::SRC_MONO;
        return rccs_pkg::SRC_TEXT;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cluster_result_t want;
        if (!rst_n)
        begin
            entry_limit     = '0;
            cluster_acc     = rccs_pkg::FACE_ALL;
            mismatch_count  = 0;
            results_checked = 0;
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_write_en)
                entry_limit = cfg_write_data;

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with none expected: source_choice %0d cluster_mask %0d",
                           source_choice, cluster_mask);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (source_choice !== want.choice)
                    begin
                        $error("source_choice: expected %0d, actual %0d",
                               want.choice, source_choice);
                        mismatch_count++;
                    end
                    if (cluster_mask !== want.mask)
                    begin
                        $error("cluster_mask: expected %0d, actual %0d",
                               want.mask, cluster_mask);
                        mismatch_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (op == rccs_pkg::OP_WRITE)
                begin
                    span_first[entry_index] = range_first;
                    span_last[entry_index]  = range_last;
                    span_faces[entry_index] = face_bits;
                end
                else
                begin
                    cluster_acc = cluster_acc & covering_set(code_point);
                    if (last_in_cluster)
                    begin
                        want.choice = pick_source(cluster_acc, text_plane);
                        want.mask   = cluster_acc;
                        expected_results.push_back(want);
                        cluster_acc = rccs_pkg::FACE_ALL;
                    end
                end
            end

            pending_results <= expected_results.size();
        end
    end

endmodule

>>> bench/range_coverage_cluster_selector_top_tb.sv
// Testbench top: drives requests and configuration, stalls results, reports the verdict.
module range_coverage_cluster_selector_top_tb;

    localparam logic [rccs_pkg::CP_W-1:0] CP_MAX = 21'h10FFFF;  // highest code point
    localparam int RANDOM_ITEMS  = 80;    // requests in the random part
    localparam int SETTLE_CYCLES = 48;    // covers a full-depth search plus output register
    localparam int LIMIT_CYCLES  = 600000;

    logic                         clk             = 1'b0;
    logic                         rst_n           = 1'b0;
    logic                         cfg_write_en    = 1'b0;
    logic [rccs_pkg::COUNT_W-1:0] cfg_write_data  = '0;
    logic                         in_valid        = 1'b0;
    logic                         in_stall;
    logic                         op              = rccs_pkg::OP_WRITE;
    logic [rccs_pkg::IDX_W-1:0]   entry_index     = '0;
    logic [rccs_pkg::CP_W-1:0]    range_first     = '0;
    logic [rccs_pkg::CP_W-1:0]    range_last      = '0;
    logic [rccs_pkg::FACE_W-1:0]  face_bits       = '0;
    logic [rccs_pkg::CP_W-1:0]    code_point      = '0;
    logic                         last_in_cluster = 1'b0;
    logic                         text_plane      = 1'b0;
    logic                         out_valid;
    logic                         out_stall       = 1'b0;
    logic [rccs_pkg::SRC_W-1:0]   source_choice;
    logic [rccs_pkg::FACE_W-1:0]  cluster_mask;

    int mismatch_count;
    int pending_results;
    int results_checked;

    // stimulus-side copy of the ranges, only used to aim lookups at entries
    logic [rccs_pkg::CP_W-1:0] aim_lo [rccs_pkg::TABLE_DEPTH];
    logic [rccs_pkg::CP_W-1:0] aim_hi [rccs_pkg::TABLE_DEPTH];

    int requests_sent = 0;
    int lookups_sent  = 0;
    int burst_left    = 0;
    int cycle_count   = 0;
    int stall_mode    = 0;
    int stall_clock   = 0;

    range_coverage_cluster_selector_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .entry_index     (entry_index),
        .range_first     (range_first),
        .range_last      (range_last),
        .face_bits       (face_bits),
        .code_point      (code_point),
        .last_in_cluster (last_in_cluster),
        .text_plane      (text_plane),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .source_choice   (source_choice),
        .cluster_mask    (cluster_mask)
    );

    cluster_result_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .entry_index     (entry_index),
        .range_first     (range_first),
        .range_last      (range_last),
        .face_bits       (face_bits),
        .code_point      (code_point),
        .last_in_cluster (last_in_cluster),
        .text_plane      (text_plane),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .source_choice   (source_choice),
        .cluster_mask    (cluster_mask),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Result side: the stall behaviour changes every so often between
    // never stalling, light and heavy random stalling, and a regular
    // on/off pattern, so stalls land on every phase of a search.
    always @(posedge clk)
    begin
        if (stall_clock == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_clock <= $urandom_range(20, 120);
        end
        else
            stall_clock <= stall_clock - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_clock % 8) < 5;
        endcase
    end

    // Present one request and hold it until the block takes it. The sender
    // runs in bursts; between bursts valid drops for a random gap (a gap of
    // zero simply merges two bursts into one longer stretch).
    task automatic send_request(input logic                        op_v,
                                input logic [rccs_pkg::IDX_W-1:0]  idx,
                                input logic [rccs_pkg::CP_W-1:0]   lo,
                                input logic [rccs_pkg::CP_W-1:0]   hi,
                                input logic [rccs_pkg::FACE_W-1:0] faces,
                                input logic [rccs_pkg::CP_W-1:0]   cp,
                                input logic                        closing,
                                input logic                        plane);
        int gap;
        in_valid        <= 1'b1;
        op              <= op_v;
        entry_index     <= idx;
        range_first     <= lo;
        range_last      <= hi;
        face_bits       <= faces;
        code_point      <= cp;
        last_in_cluster <= closing;
        text_plane      <= plane;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Table write; the lookup-side fields carry noise.
    task automatic store_range(input int idx, input logic [rccs_pkg::CP_W-1:0] lo,
                               input logic [rccs_pkg::CP_W-1:0] hi,
                               input logic [rccs_pkg::FACE_W-1:0] faces);
        aim_lo[idx] = lo;
        aim_hi[idx] = hi;
        send_request(rccs_pkg::OP_WRITE, rccs_pkg::IDX_W'(idx), lo, hi, faces,
                     rccs_pkg::CP_W'($urandom_range(0, CP_MAX)), 1'($urandom), 1'($urandom));
    endtask

    // Lookup; the write-side fields carry noise.
    task automatic look_up(input logic [rccs_pkg::CP_W-1:0] cp, input logic closing,
                           input logic plane);
        lookups_sent++;
        send_request(rccs_pkg::OP_LOOKUP, rccs_pkg::IDX_W'($urandom),
                     rccs_pkg::CP_W'($urandom_range(0, CP_MAX)),
                     rccs_pkg::CP_W'($urandom_range(0, CP_MAX)),
                     rccs_pkg::FACE_W'($urandom), cp, closing, plane);
    endtask

    // Only while idle: nothing offered, nothing outstanding.
    task automatic set_entry_count(input int cnt);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= rccs_pkg::COUNT_W'(cnt);
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Wait for every expected result, then let a non-closing lookup finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // n sorted, non-overlapping ranges spread over the code space, with
    // random gaps, some single-point ranges, and a bias towards full sets
    // so that cluster masks do not collapse to empty straight away.
    task automatic fill_sorted(input int n);
        int step;
        int half;
        int lo;
        int hi;
        logic [rccs_pkg::FACE_W-1:0] faces;
        step = 32'h110000 / n;
        half = step / 2;
        for (int i = 0; i < n; i++)
        begin
            lo = i * step + $urandom_range(0, half);
            hi = ($urandom_range(0, 7) == 0) ? lo : lo + $urandom_range(0, half - 1);
            faces = $urandom_range(0, 1) ? rccs_pkg::FACE_ALL
                                         : rccs_pkg::FACE_W'($urandom_range(0, 7));
            store_range(i, rccs_pkg::CP_W'(lo), rccs_pkg::CP_W'(hi), faces);
        end
    endtask

    // Mostly points inside a live range, some just outside one, some anywhere.
    function automatic logic [rccs_pkg::CP_W-1:0] pick_point(input int n);
        int i;
        int r;
        int lo;
        int hi;
        int p;
        if (n == 0)
            return rccs_pkg::CP_W'($urandom_range(0, CP_MAX));
        r  = $urandom_range(0, 9);
        i  = $urandom_range(0, n - 1);
        lo = aim_lo[i];
        hi = aim_hi[i];
        if (r < 7)
            p = (hi >= lo) ? lo + $urandom_range(0, hi - lo) : lo;
        else if (r == 7)
            p = $urandom_range(0, 1) ? lo - 1 : hi + 1;
        else
            p = $urandom_range(0, CP_MAX);
        if (p < 0)
            p = 0;
        if (p > CP_MAX)
            p = CP_MAX;
        return rccs_pkg::CP_W'(p);
    endfunction

    // Whole clusters of lookups, mostly short, now and then long; a stray
    // table write sometimes lands inside a cluster (and may unsort the table).
    task automatic run_clusters(input int n, input int quota);
        int done;
        int len;
        done = 0;
        while (done < quota)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
            begin
                if (n > 0 && $urandom_range(0, 19) == 0)
                begin
                    store_range($urandom_range(0, n - 1),
                                rccs_pkg::CP_W'($urandom_range(0, CP_MAX)),
                                rccs_pkg::CP_W'($urandom_range(0, CP_MAX)),
                                rccs_pkg::FACE_W'($urandom));
                    done++;
                end
                look_up(pick_point(n), k == len - 1, 1'($urandom));
                done++;
            end
        end
    endtask

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int cnt;
        int n;
        int random_start;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Empty table: any lookup misses, the result is none with an empty mask.
        set_entry_count(0);
        look_up(CP_MAX, 1'b1, 1'b0);

        // Four ranges whose sets exercise both priority orders.
        store_range(0, 21'h000000, 21'h00001F, rccs_pkg::FACE_ALL);
        store_range(1, 21'h000100, 21'h0001FF, rccs_pkg::FACE_MONO | rccs_pkg::FACE_TEXT);
        store_range(2, 21'h01F000, 21'h01FFFF, rccs_pkg::FACE_EMOJI | rccs_pkg::FACE_TEXT);
        store_range(3, 21'h10FFF0, CP_MAX, rccs_pkg::FACE_EMOJI);
        wait_idle();
        set_entry_count(4);

        look_up(21'h000000, 1'b1, 1'b0);   // full set, colour order: emoji
        look_up(21'h00001F, 1'b1, 1'b1);   // full set, mono order: mono
        look_up(21'h000100, 1'b1, 1'b0);   // mono+text: mono
        look_up(21'h01F800, 1'b1, 1'b1);   // emoji+text, mono order: text
        look_up(21'h000150, 1'b0, 1'b0);   // two-point cluster narrows to text only
        look_up(21'h01FFFF, 1'b1, 1'b0);
        look_up(CP_MAX, 1'b1, 1'b1);       // emoji only, mono order falls back to emoji
        look_up(21'h10FFF0, 1'b1, 1'b0);
        look_up(21'h000050, 1'b1, 1'b0);   // gap between ranges: miss
        // mask empties mid-cluster and stays empty to the end
        look_up(21'h020000, 1'b0, 1'b1);
        look_up(21'h000000, 1'b0, 1'b1);
        look_up(21'h01F000, 1'b1, 1'b1);
        // table write inside a cluster leaves the running mask alone
        look_up(21'h000000, 1'b0, 1'b0);
        store_range(1, 21'h000100, 21'h0001FF, rccs_pkg::FACE_MONO);
        look_up(21'h000180, 1'b1, 1'b0);
        // overlapping, unsorted table: the search answer is taken as it falls
        store_range(2, 21'h000000, CP_MAX, rccs_pkg::FACE_EMOJI | rccs_pkg::FACE_MONO);
        look_up(21'h01F000, 1'b1, 1'b1);
        look_up(21'h000010, 1'b1, 1'b0);
        wait_idle();

        // ---- full table: deepest search, then a count above the depth ----
        fill_sorted(rccs_pkg::TABLE_DEPTH);
        wait_idle();
        set_entry_count(rccs_pkg::TABLE_DEPTH);
        run_clusters(rccs_pkg::TABLE_DEPTH, 32);
        wait_idle();
        set_entry_count(2047);
        run_clusters(rccs_pkg::TABLE_DEPTH, 24);
        wait_idle();

        // ---- random phases ----
        // Every entry is written by now, so any count is safe to search.
        // Mostly small freshly sorted tables; some phases reuse the table
        // as it stands with a large count, some use an empty table.
        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       cnt = 0;
                1:       cnt = 1;
                2:       cnt = $urandom_range(17, 2047);
                default: cnt = $urandom_range(2, 16);
            endcase
            n = (cnt > rccs_pkg::TABLE_DEPTH) ? rccs_pkg::TABLE_DEPTH : cnt;
            set_entry_count(cnt);
            if (cnt >= 1 && cnt <= 16)
                fill_sorted(n);
            run_clusters(n, $urandom_range(8, 24));
            wait_idle();
        end

        $display("tb: %0d requests sent, %0d of them lookups; %0d cluster results compared",
                 requests_sent, lookups_sent, results_checked);
        $display("tb: entry counts from empty through a full table and above the depth");
        if (mismatch_count == 0 && pending_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
